// ===== rtl/rrp_pkg.sv =====
// Package for the RV32 relocation patcher: relocation kinds, status codes,
// word types of both channels and the immediate insert functions.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rrp_pkg;

    // Relocation kinds.
    localparam logic [3:0] OP_MARKER    = 4'd0;
    localparam logic [3:0] OP_ABS32     = 4'd1;
    localparam logic [3:0] OP_PCREL32   = 4'd2;
    localparam logic [3:0] OP_ADD32     = 4'd3;
    localparam logic [3:0] OP_SUB32     = 4'd4;
    localparam logic [3:0] OP_BRANCH    = 4'd5;
    localparam logic [3:0] OP_JAL       = 4'd6;
    localparam logic [3:0] OP_HI20      = 4'd7;
    localparam logic [3:0] OP_LO12I     = 4'd8;
    localparam logic [3:0] OP_LO12S     = 4'd9;
    localparam logic [3:0] OP_PCRELHI   = 4'd10;
    localparam logic [3:0] OP_GOTHI     = 4'd11;
    localparam logic [3:0] OP_PCRELLO_I = 4'd12;
    localparam logic [3:0] OP_PCRELLO_S = 4'd13;
    localparam logic [3:0] OP_CALL      = 4'd14;
    localparam logic [3:0] OP_OTHER     = 4'd15;

    // Result status codes.
    localparam logic [2:0] ST_PATCHED     = 3'd0;
    localparam logic [2:0] ST_MARKER      = 3'd1;
    localparam logic [2:0] ST_BRANCH_OOR  = 3'd2;
    localparam logic [2:0] ST_JAL_OOR     = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    // Bits of the original word kept by each immediate format.
    localparam logic [31:0] HI_ROUND    = 32'h0000_0800;
    localparam logic [31:0] MASK_U_KEEP = 32'h0000_0fff;
    localparam logic [31:0] MASK_I_KEEP = 32'h000f_ffff;
    localparam logic [31:0] MASK_SB_KEEP = 32'h01ff_f07f;

    // One relocation word.
    typedef struct packed {
        logic [3:0]         op;
        logic [31:0]        sym_value;
        logic signed [31:0] addend;
        logic [31:0]        site_addr;
        logic [31:0]        orig_word;
        logic [31:0]        next_word;
        logic [31:0]        partner_disp;
        logic [31:0]        got_entry_addr;
    } reloc_t;

    // One patch result word.
    typedef struct packed {
        logic [31:0] new_word;
        logic [31:0] new_next_word;
        logic        next_written;
        logic [2:0]  status;
    } patch_t;

    // U-type: upper 20 bits with rounding so that a signed lo12 adds back.
    function automatic logic [31:0] put_u(input logic [31:0] w, input logic [31:0] v);
        logic [31:0] r;
        begin
            r = v + HI_ROUND;
            return (w & MASK_U_KEEP) | {r[31:12], 12'd0};
        end
    endfunction

    // I-type: low 12 bits into bits 31:20.
    function automatic logic [31:0] put_i(input logic [31:0] w, input logic [31:0] v);
        return (w & MASK_I_KEEP) | {v[11:0], 20'd0};
    endfunction

    // S-type: low 12 bits split over bits 31:25 and 11:7.
    function automatic logic [31:0] put_s(input logic [31:0] w, input logic [31:0] v);
        return (w & MASK_SB_KEEP) | {v[11:5], 13'd0, v[4:0], 7'd0};
    endfunction

    // B-type: 13-bit displacement, bit 0 not encoded.
    function automatic logic [31:0] put_b(input logic [31:0] w, input logic [31:0] d);
        return (w & MASK_SB_KEEP) | {d[12], d[10:5], 13'd0, d[4:1], d[11], 7'd0};
    endfunction

    // J-type: 21-bit displacement, bit 0 not encoded.
    function automatic logic [31:0] put_j(input logic [31:0] w, input logic [31:0] d);
        return (w & MASK_U_KEEP) | {d[20], d[10:1], d[11], d[19:12], 12'd0};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rrp_in_if.sv =====
// Valid/ready channel that carries relocation words into the patcher.
// Depends on rrp_pkg for the word type.
`default_nettype none

interface rrp_in_if;
    logic           valid;
    logic           ready;
    rrp_pkg::reloc_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrp_out_if.sv =====
// Valid/ready channel that carries patch result words out of the patcher.
// Depends on rrp_pkg for the word type.
`default_nettype none

interface rrp_out_if;
    logic           valid;
    logic           ready;
    rrp_pkg::patch_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/riscv_relocation_patcher.sv =====
// Top level of the RV32 relocation patcher: a three-stage pipeline.
// Depends on rrp_pkg, rrp_in_if and rrp_out_if.
//
//   Channel  Dir  Word       Meaning
//   reloc    in   reloc_t    one relocation with its site words
//   patch    out  patch_t    patched words and status
//
// Every relocation passes through the stages in order: sums, value select,
// then range check and immediate insert into the output register.
// A new word is taken in every cycle while the output is being drained.
// Each stage holds while the stage after it is full and stalled; a stage
// that is empty fills even when the output stalls.
// Reset clears the stage valid bits only; the payload registers are not reset.
`default_nettype none

module riscv_relocation_patcher (
    input  wire        clk,
    input  wire        rst_n,
    rrp_in_if.sink     reloc,
    rrp_out_if.source  patch
);

    // Stage 1: first-level sums.
    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] sa;
        logic [31:0] got_rel;
        logic [31:0] site_addr;
        logic [31:0] orig_word;
        logic [31:0] next_word;
        logic [31:0] partner_disp;
    } s1_t;

    // Stage 2: the value that gets written, selected by kind.
    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] val;
        logic [31:0] orig_word;
        logic [31:0] next_word;
    } s2_t;

    logic                v1_reg, v2_reg, v3_reg;
    s1_t                 s1_reg, s1_next;
    s2_t                 s2_reg, s2_next;
    rrp_pkg::patch_t     s3_reg, s3_next;
    logic                adv1, adv2, adv3;

    // Each stage moves when it is empty or the next one moves.
    assign adv3 = !v3_reg || patch.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign reloc.ready = adv1;
    assign patch.valid = v3_reg;
    assign patch.data  = s3_reg;

    // Stage 1 logic: S + A and the GOT displacement.
    always_comb
    begin
        s1_next.op           = reloc.data.op;
        s1_next.sa           = reloc.data.sym_value + reloc.data.addend;
        s1_next.got_rel      = reloc.data.got_entry_addr - reloc.data.site_addr;
        s1_next.site_addr    = reloc.data.site_addr;
        s1_next.orig_word    = reloc.data.orig_word;
        s1_next.next_word    = reloc.data.next_word;
        s1_next.partner_disp = reloc.data.partner_disp;
    end

    // Stage 2 logic: value select by kind, with PC-relative and data-word arithmetic.
    always_comb
    begin
        s2_next.op        = s1_reg.op;
        s2_next.orig_word = s1_reg.orig_word;
        s2_next.next_word = s1_reg.next_word;
        case (s1_reg.op) inside
            rrp_pkg::OP_ABS32, rrp_pkg::OP_HI20, rrp_pkg::OP_LO12I,
            rrp_pkg::OP_LO12S:
                s2_next.val = s1_reg.sa;
            rrp_pkg::OP_PCREL32, rrp_pkg::OP_BRANCH, rrp_pkg::OP_JAL,
            rrp_pkg::OP_PCRELHI, rrp_pkg::OP_CALL:
                s2_next.val = s1_reg.sa - s1_reg.site_addr;
            rrp_pkg::OP_ADD32:
                s2_next.val = s1_reg.orig_word + s1_reg.sa;
            rrp_pkg::OP_SUB32:
                s2_next.val = s1_reg.orig_word - s1_reg.sa;
            rrp_pkg::OP_GOTHI:
                s2_next.val = s1_reg.got_rel;
            rrp_pkg::OP_PCRELLO_I, rrp_pkg::OP_PCRELLO_S:
                s2_next.val = s1_reg.partner_disp;
            default:
                s2_next.val = s1_reg.sa;
        endcase
    end

    // Stage 3 logic: range check and immediate insert.
    always_comb
    begin
        s3_next.new_word      = s2_reg.orig_word;
        s3_next.new_next_word = s2_reg.next_word;
        s3_next.next_written  = 1'b0;
        s3_next.status        = rrp_pkg::ST_PATCHED;
        case (s2_reg.op) inside
            rrp_pkg::OP_MARKER:
                s3_next.status = rrp_pkg::ST_MARKER;
            rrp_pkg::OP_ABS32, rrp_pkg::OP_PCREL32, rrp_pkg::OP_ADD32,
            rrp_pkg::OP_SUB32:
                s3_next.new_word = s2_reg.val;
            rrp_pkg::OP_BRANCH:
            begin
                // In range when bits 31:12 are a plain sign extension.
                if (&s2_reg.val[31:12] || !(|s2_reg.val[31:12]))
                    s3_next.new_word = rrp_pkg::put_b(s2_reg.orig_word, s2_reg.val);
                else
                    s3_next.status = rrp_pkg::ST_BRANCH_OOR;
            end
            rrp_pkg::OP_JAL:
            begin
                if (&s2_reg.val[31:20] || !(|s2_reg.val[31:20]))
                    s3_next.new_word = rrp_pkg::put_j(s2_reg.orig_word, s2_reg.val);
                else
                    s3_next.status = rrp_pkg::ST_JAL_OOR;
            end
            rrp_pkg::OP_HI20, rrp_pkg::OP_PCRELHI, rrp_pkg::OP_GOTHI:
                s3_next.new_word = rrp_pkg::put_u(s2_reg.orig_word, s2_reg.val);
            rrp_pkg::OP_LO12I, rrp_pkg::OP_PCRELLO_I:
                s3_next.new_word = rrp_pkg::put_i(s2_reg.orig_word, s2_reg.val);
            rrp_pkg::OP_LO12S, rrp_pkg::OP_PCRELLO_S:
                s3_next.new_word = rrp_pkg::put_s(s2_reg.orig_word, s2_reg.val);
            rrp_pkg::OP_CALL:
            begin
                s3_next.new_word      = rrp_pkg::put_u(s2_reg.orig_word, s2_reg.val);
                s3_next.new_next_word = rrp_pkg::put_i(s2_reg.next_word, s2_reg.val);
                s3_next.next_written  = 1'b1;
            end
            default:
                s3_next.status = rrp_pkg::ST_UNSUPPORTED;
        endcase
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= reloc.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // Stage payload registers load only when a valid word moves in.
    always_ff @(posedge clk)
    begin
        if (adv1 && reloc.valid)
            s1_reg <= s1_next;
        if (adv2 && v1_reg)
            s2_reg <= s2_next;
        if (adv3 && v2_reg)
            s3_reg <= s3_next;
    end

    // The input stalls only when every stage holds a word.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !reloc.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with an empty pipeline stage");

    // A word that leaves stage 1 always arrives in stage 2.
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2) |=> v2_reg)
        else $error("word lost between stage 1 and stage 2");

    // Only a patched call pair writes the following word.
    a_next_only_patched: assert property (@(posedge clk) disable iff (!rst_n)
        (patch.valid && patch.data.next_written) |->
            (patch.data.status == rrp_pkg::ST_PATCHED))
        else $error("following word written with a failure status");

endmodule

`default_nettype wire
